@@ rtl/mhts_pkg.sv @@
// Package with the types, codes and constants shared by the timer queue modules.
package mhts_pkg;

   localparam int HEAP_DEPTH_DEF  = 16;
   localparam int JOB_ID_BITS_DEF = 8;
   localparam int MAX_RESULTS     = 16;
   localparam int ID_W            = 8;
   localparam int TIME_W          = 32;
   localparam int IVL_W           = 31;

   localparam logic [1:0] MODE_SCHEDULE = 2'd0;
   localparam logic [1:0] MODE_TICK     = 2'd1;
   localparam logic [1:0] MODE_STOP     = 2'd2;

   localparam logic [1:0] KIND_ACCEPT = 2'd0;
   localparam logic [1:0] KIND_REJECT = 2'd1;
   localparam logic [1:0] KIND_FIRED  = 2'd2;

   localparam logic [TIME_W-1:0] KEY_BIAS = 32'h8000_0000;

   typedef struct packed {
      logic [1:0]        mode;
      logic [ID_W-1:0]   job_id;
      logic [TIME_W-1:0] due_time;
      logic [IVL_W-1:0]  repeat_interval;
   } req_type;

   typedef struct packed {
      logic [1:0]        kind;
      logic [ID_W-1:0]   fired_id;
      logic [TIME_W-1:0] fire_time;
      logic              last;
   } rsp_type;

   typedef enum logic [1:0] {
      CMD_SCHEDULE,
      CMD_TICK,
      CMD_STOP
   } cmd_op_type;

   typedef struct packed {
      cmd_op_type        op;
      logic [ID_W-1:0]   job_id;
      logic [TIME_W-1:0] due_time;
      logic [IVL_W-1:0]  interval;
   } cmd_type;

   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } cmd_head_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_READ,
      BK_CMP,
      BK_FIRE,
      BK_MOVE_RD,
      BK_MOVE_WR,
      BK_FINISH
   } back_state_type;

endpackage

@@ rtl/mhts_front.sv @@
// Front end: takes transactions, decodes them into commands and queues them.
module mhts_front import mhts_pkg::*; #(
   parameter int JOB_ID_BITS = JOB_ID_BITS_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   input  req_type      req_data,
   output cmd_head_type head,
   input  logic         pop
);

   localparam logic [ID_W-1:0] ID_MASK = ID_W'((33'd1 << JOB_ID_BITS) - 33'd1);

   cmd_type    q_ff [2];
   logic       wptr_ff, wptr_in, rptr_ff, rptr_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       push;
   cmd_type    cmd;

   always_comb begin
      cmd.job_id   = req_data.job_id & ID_MASK;
      cmd.due_time = req_data.due_time;
      cmd.interval = req_data.repeat_interval;
      cmd.op       = CMD_TICK;
      push         = 1'b0;
      if (start && !busy) begin
         unique case (req_data.mode)
            MODE_SCHEDULE: begin
               cmd.op = CMD_SCHEDULE;
               push   = 1'b1;
            end
            MODE_TICK: begin
               cmd.op = CMD_TICK;
               push   = 1'b1;
            end
            MODE_STOP: begin
               cmd.op = CMD_STOP;
               push   = 1'b1;
            end
            default: push = 1'b0;
         endcase
      end
      wptr_in = push ? ~wptr_ff : wptr_ff;
      rptr_in = pop ? ~rptr_ff : rptr_ff;
      cnt_in  = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   assign busy       = (cnt_ff == 2'd2);
   assign head.valid = (cnt_ff != 2'd0);
   assign head.cmd   = q_ff[rptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= 1'b0;
         rptr_ff <= 1'b0;
         cnt_ff  <= 2'd0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         cnt_ff  <= cnt_in;
      end
      if (push) begin
         q_ff[wptr_ff] <= cmd;
      end
   end

endmodule

@@ rtl/mhts_back.sv @@
// Back end: runs commands against the job store and produces the results.
module mhts_back import mhts_pkg::*; #(
   parameter int HEAP_DEPTH  = HEAP_DEPTH_DEF,
   parameter int JOB_ID_BITS = JOB_ID_BITS_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  cmd_head_type head,
   output logic         pop,
   output logic         rsp_valid,
   output rsp_type      rsp_data
);

   localparam int IDX_W = (HEAP_DEPTH > 1) ? $clog2(HEAP_DEPTH) : 1;
   localparam int CNT_W = $clog2(HEAP_DEPTH + 1);
   localparam int N_W   = $clog2(MAX_RESULTS + 1);

   typedef struct packed {
      logic [TIME_W-1:0]      due;
      logic [IVL_W-1:0]       ivl;
      logic [JOB_ID_BITS-1:0] job;
   } entry_type;

   entry_type mem [HEAP_DEPTH];
   entry_type rd_data_ff, wr_data;
   logic [IDX_W-1:0] rd_addr, wr_addr;
   logic             wr_en;

   back_state_type         state_ff, state_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic [TIME_W-1:0]      now_ff, now_in;
   logic                   stopped_ff, stopped_in;
   logic [IDX_W-1:0]       idx_ff, idx_in, best_idx_ff, best_idx_in;
   logic [TIME_W-1:0]      best_key_ff, best_key_in;
   logic [JOB_ID_BITS-1:0] best_job_ff, best_job_in, pend_ff, pend_in;
   logic [IVL_W-1:0]       best_ivl_ff, best_ivl_in;
   logic                   pend_valid_ff, pend_valid_in;
   logic [N_W-1:0]         n_ff, n_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_type                rsp_ff, rsp_in;
   logic [TIME_W-1:0]      key;
   logic                   better;
   logic [CNT_W-1:0]       count_dec;

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      now_in        = now_ff;
      stopped_in    = stopped_ff;
      idx_in        = idx_ff;
      best_idx_in   = best_idx_ff;
      best_key_in   = best_key_ff;
      best_job_in   = best_job_ff;
      best_ivl_in   = best_ivl_ff;
      pend_in       = pend_ff;
      pend_valid_in = pend_valid_ff;
      n_in          = n_ff;
      rsp_valid_in  = 1'b0;
      rsp_in        = rsp_ff;
      pop           = 1'b0;
      wr_en         = 1'b0;
      wr_addr       = IDX_W'(count_ff);
      wr_data.due   = head.cmd.due_time;
      wr_data.ivl   = head.cmd.interval;
      wr_data.job   = JOB_ID_BITS'(head.cmd.job_id);
      rd_addr       = idx_ff;
      count_dec     = count_ff - CNT_W'(1);
      key           = (rd_data_ff.due - now_ff) ^ KEY_BIAS;
      better        = (idx_ff == '0) || (key < best_key_ff) ||
                      ((key == best_key_ff) && (rd_data_ff.job < best_job_ff));
      unique case (state_ff)
         BK_IDLE: begin
            if (head.valid) begin
               pop = 1'b1;
               unique case (head.cmd.op)
                  CMD_STOP: begin
                     count_in   = '0;
                     stopped_in = 1'b1;
                  end
                  CMD_SCHEDULE: begin
                     rsp_valid_in     = 1'b1;
                     rsp_in.fired_id  = head.cmd.job_id;
                     rsp_in.fire_time = now_ff;
                     rsp_in.last      = 1'b1;
                     if (stopped_ff || (count_ff == CNT_W'(HEAP_DEPTH))) begin
                        rsp_in.kind = KIND_REJECT;
                     end else begin
                        rsp_in.kind = KIND_ACCEPT;
                        wr_en       = 1'b1;
                        count_in    = count_ff + CNT_W'(1);
                     end
                  end
                  CMD_TICK: begin
                     if (!stopped_ff) begin
                        now_in        = now_ff + TIME_W'(1);
                        n_in          = '0;
                        pend_valid_in = 1'b0;
                        idx_in        = '0;
                        if (count_ff != '0) begin
                           state_in = BK_READ;
                        end
                     end
                  end
                  default: state_in = BK_IDLE;
               endcase
            end
         end
         BK_READ: begin
            state_in = BK_CMP;
         end
         BK_CMP: begin
            if (better) begin
               best_idx_in = idx_ff;
               best_key_in = key;
               best_job_in = rd_data_ff.job;
               best_ivl_in = rd_data_ff.ivl;
            end
            if (CNT_W'(idx_ff) == count_dec) begin
               state_in = ((better ? key : best_key_ff) <= KEY_BIAS) ? BK_FIRE : BK_FINISH;
            end else begin
               idx_in   = idx_ff + IDX_W'(1);
               state_in = BK_READ;
            end
         end
         BK_FIRE: begin
            if (pend_valid_ff) begin
               rsp_valid_in     = 1'b1;
               rsp_in.kind      = KIND_FIRED;
               rsp_in.fired_id  = ID_W'(pend_ff);
               rsp_in.fire_time = now_ff;
               rsp_in.last      = 1'b0;
            end
            pend_in       = best_job_ff;
            pend_valid_in = 1'b1;
            n_in          = n_ff + N_W'(1);
            idx_in        = '0;
            if (best_ivl_ff != '0) begin
               wr_en       = 1'b1;
               wr_addr     = best_idx_ff;
               wr_data.due = now_ff + TIME_W'(best_ivl_ff);
               wr_data.ivl = best_ivl_ff;
               wr_data.job = best_job_ff;
               state_in    = (n_in < N_W'(MAX_RESULTS)) ? BK_READ : BK_FINISH;
            end else begin
               state_in = BK_MOVE_RD;
            end
         end
         BK_MOVE_RD: begin
            rd_addr  = IDX_W'(count_dec);
            state_in = BK_MOVE_WR;
         end
         BK_MOVE_WR: begin
            wr_en    = 1'b1;
            wr_addr  = best_idx_ff;
            wr_data  = rd_data_ff;
            count_in = count_dec;
            state_in = ((n_ff < N_W'(MAX_RESULTS)) && (count_dec != '0)) ? BK_READ : BK_FINISH;
         end
         BK_FINISH: begin
            if (pend_valid_ff) begin
               rsp_valid_in     = 1'b1;
               rsp_in.kind      = KIND_FIRED;
               rsp_in.fired_id  = ID_W'(pend_ff);
               rsp_in.fire_time = now_ff;
               rsp_in.last      = 1'b1;
            end
            pend_valid_in = 1'b0;
            state_in      = BK_IDLE;
         end
         default: state_in = BK_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= BK_IDLE;
         count_ff      <= '0;
         now_ff        <= '0;
         stopped_ff    <= 1'b0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         now_ff        <= now_in;
         stopped_ff    <= stopped_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      idx_ff      <= idx_in;
      best_idx_ff <= best_idx_in;
      best_key_ff <= best_key_in;
      best_job_ff <= best_job_in;
      best_ivl_ff <= best_ivl_in;
      pend_ff     <= pend_in;
      n_ff        <= n_in;
      rsp_ff      <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

@@ rtl/min_heap_timer_scheduler_core.sv @@
// Top level of the timer queue: front end, command queue and job store back end.
//
//   Channel   Ports                      Handshake
//   request   start, busy, req_data      taken when start is high and busy is low
//   response  rsp_valid, rsp_data        one cycle per result, always taken
//
// A schedule's result passes through the command queue and the response register, and it
// waits while a tick is in progress. A tick scans the stored jobs one entry at a time through
// the single read port of the job store, and scans them anew for each fired job. Reset is
// synchronous and leaves the queue empty and running. The receiver cannot stall; the two-entry
// command queue raises busy when full.
module min_heap_timer_scheduler_core import mhts_pkg::*; #(
   parameter int HEAP_DEPTH  = HEAP_DEPTH_DEF,
   parameter int JOB_ID_BITS = JOB_ID_BITS_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_valid,
   output rsp_type rsp_data
);

   cmd_head_type head;
   logic         pop;

   mhts_front #(.JOB_ID_BITS(JOB_ID_BITS)) u_front (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .head(head), .pop(pop)
   );

   mhts_back #(.HEAP_DEPTH(HEAP_DEPTH), .JOB_ID_BITS(JOB_ID_BITS)) u_back (
      .clock(clock), .reset(reset), .head(head), .pop(pop),
      .rsp_valid(rsp_valid), .rsp_data(rsp_data)
   );

endmodule

@@ rtl/mhts_checker.sv @@
// Port-level assertions for the timer queue and their binding to the top level.
module mhts_checker import mhts_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    busy,
   input logic    rsp_valid,
   input rsp_type rsp_data
);

   a_kind_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.kind == KIND_ACCEPT || rsp_data.kind == KIND_REJECT ||
                     rsp_data.kind == KIND_FIRED))
      else $error("Result carries an unused kind.");

   a_sched_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.kind != KIND_FIRED) |-> rsp_data.last)
      else $error("Schedule result is not marked last.");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> (!rsp_valid && !busy))
      else $error("Block is not quiet after reset.");

   a_fire_time: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.kind == KIND_FIRED && !rsp_data.last) ##1 rsp_valid
      |-> rsp_data.fire_time == $past(rsp_data.fire_time))
      else $error("Fired results of one tick differ in time.");

endmodule

bind min_heap_timer_scheduler_core mhts_checker u_mhts_checker (
   .clock(clock), .reset(reset), .busy(busy),
   .rsp_valid(rsp_valid), .rsp_data(rsp_data)
);

@@ dv/tb_min_heap_timer_scheduler_core.sv @@
// Self-checking testbench for the timer queue core: directed table, then random traffic.
`timescale 1ns / 1ps

module tb_min_heap_timer_scheduler_core;
   import mhts_pkg::*;

   localparam int DEPTH = HEAP_DEPTH_DEF;

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_data;
   logic    rsp_valid;
   rsp_type rsp_data;

   min_heap_timer_scheduler_core dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_valid(rsp_valid), .rsp_data(rsp_data)
   );

   logic [TIME_W-1:0] job_due [DEPTH];
   logic [IVL_W-1:0]  job_ivl [DEPTH];
   logic [ID_W-1:0]   job_tag [DEPTH];
   int                job_count;
   logic [TIME_W-1:0] now_time;
   logic              halted;

   rsp_type expected_rsp[$];
   int      mismatches;
   int      rsp_seen;
   int      items_sent;

   typedef struct {
      req_type req;
      logic    has_exp;
      rsp_type exp;
   } row_type;

   row_type rows[$];

   function automatic void emit_result(logic [1:0] kind, logic [ID_W-1:0] id,
                                       logic last);
      rsp_type r;
      r.kind = kind;
      r.fired_id = id;
      r.fire_time = now_time;
      r.last = last;
      expected_rsp.push_back(r);
   endfunction

   function automatic void predict_transaction(req_type rq);
      int fired;
      int best;
      logic [TIME_W-1:0] bkey;
      logic [TIME_W-1:0] k;
      fired = 0;
      if (rq.mode == MODE_SCHEDULE) begin
         if (halted || job_count >= DEPTH) begin
            emit_result(KIND_REJECT, rq.job_id, 1'b1);
         end else begin
            job_due[job_count] = rq.due_time;
            job_ivl[job_count] = rq.repeat_interval;
            job_tag[job_count] = rq.job_id;
            job_count++;
            emit_result(KIND_ACCEPT, rq.job_id, 1'b1);
         end
      end else if (rq.mode == MODE_STOP) begin
         job_count = 0;
         halted = 1'b1;
      end else if (rq.mode == MODE_TICK && !halted) begin
         now_time = now_time + 1;
         while (fired < MAX_RESULTS && job_count > 0) begin
            best = 0;
            bkey = (job_due[0] - now_time) ^ KEY_BIAS;
            for (int i = 1; i < job_count; i++) begin
               k = (job_due[i] - now_time) ^ KEY_BIAS;
               if (k < bkey || (k == bkey && job_tag[i] < job_tag[best])) begin
                  best = i;
                  bkey = k;
               end
            end
            if (bkey > KEY_BIAS) break;
            emit_result(KIND_FIRED, job_tag[best], 1'b0);
            fired++;
            if (job_ivl[best] != 0) begin
               job_due[best] = now_time + job_ivl[best];
            end else begin
               job_due[best] = job_due[job_count-1];
               job_ivl[best] = job_ivl[job_count-1];
               job_tag[best] = job_tag[job_count-1];
               job_count--;
            end
         end
         if (fired > 0) expected_rsp[$].last = 1'b1;
      end
   endfunction

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #50ms;
      $display("Timeout with %0d results outstanding", expected_rsp.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   always @(posedge clock) begin
      rsp_type e;
      if (!reset && rsp_valid) begin
         rsp_seen++;
         if (expected_rsp.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("Unexpected result %p", rsp_data);
         end else begin
            e = expected_rsp.pop_front();
            if (rsp_data.kind !== e.kind || rsp_data.fired_id !== e.fired_id ||
                rsp_data.fire_time !== e.fire_time || rsp_data.last !== e.last) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("Mismatch: expected %p, got %p", e, rsp_data);
            end
         end
      end
   end

   function automatic req_type make_req(logic [1:0] mode, logic [ID_W-1:0] id,
                                        logic [TIME_W-1:0] due, logic [IVL_W-1:0] ivl);
      req_type r;
      r.mode = mode;
      r.job_id = id;
      r.due_time = due;
      r.repeat_interval = ivl;
      return r;
   endfunction

   function automatic void add_row(req_type rq, logic has_exp, logic [1:0] kind);
      row_type rw;
      rw.req = rq;
      rw.has_exp = has_exp;
      rw.exp.kind = kind;
      rw.exp.fired_id = rq.job_id;
      rw.exp.fire_time = '0;
      rw.exp.last = 1'b1;
      rows.push_back(rw);
   endfunction

   task automatic send_item(req_type rq);
      int gap;
      gap = $urandom_range(0, 11);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_data <= rq;
      @(posedge clock);
      while (busy) @(posedge clock);
      predict_transaction(rq);
      items_sent++;
   endtask

   function automatic req_type random_req(int phase);
      req_type r;
      int pick;
      r.job_id = ID_W'($urandom);
      r.due_time = now_time + $urandom_range(0, 6);
      r.repeat_interval = ($urandom_range(0, 2) == 0) ? 31'd0 :
                          IVL_W'($urandom_range(1, 5));
      pick = $urandom_range(0, 99);
      if (pick < 45) r.mode = MODE_SCHEDULE;
      else r.mode = MODE_TICK;
      if ($urandom_range(0, 9) == 0) begin
         r.due_time = $urandom;
         r.repeat_interval = IVL_W'($urandom);
      end
      if (pick == 99 && phase == 1) r.mode = 2'd3;
      return r;
   endfunction

   initial begin
      int n;
      reset = 1'b1;
      start = 1'b0;
      req_data = '0;
      job_count = 0;
      now_time = '0;
      halted = 1'b0;
      mismatches = 0;
      rsp_seen = 0;
      items_sent = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed table: extremes, schedule, tick and the unused mode, due-at-once, ties, wrap and overflow.
      add_row(make_req(MODE_SCHEDULE, 8'hFF, 32'hFFFF_FFFF, 31'h7FFF_FFFF), 1, KIND_ACCEPT);
      add_row(make_req(MODE_SCHEDULE, 8'h00, 32'h0000_0000, 31'd0), 1, KIND_ACCEPT);
      add_row(make_req(MODE_SCHEDULE, 8'h05, 32'd1, 31'd0), 1, KIND_ACCEPT);
      add_row(make_req(MODE_SCHEDULE, 8'h03, 32'd1, 31'd2), 1, KIND_ACCEPT);
      add_row(make_req(MODE_TICK, 8'hAA, 32'h5555_5555, 31'h2AAA_AAAA), 0, 0);
      add_row(make_req(2'd3, 8'h11, 32'd0, 31'd0), 0, 0);
      add_row(make_req(MODE_TICK, 8'h00, 32'd0, 31'd0), 0, 0);
      add_row(make_req(MODE_TICK, 8'h00, 32'd0, 31'd0), 0, 0);
      add_row(make_req(MODE_SCHEDULE, 8'h80, 32'h8000_0003, 31'd1), 0, 0);
      for (int i = 0; i < 14; i++)
         add_row(make_req(MODE_SCHEDULE, 8'(i), 32'd4, 31'(i % 2)), 0, 0);
      add_row(make_req(MODE_TICK, 8'h00, 32'd0, 31'd0), 0, 0);
      foreach (rows[i]) begin
         send_item(rows[i].req);
         if (rows[i].has_exp) expected_rsp[$] = rows[i].exp;
      end

      // Random traffic, with occasional bursts of ticks to drain the heap when it is full.
      n = 0;
      while (n < 185) begin
         send_item(random_req(1));
         n++;
         if (job_count == DEPTH && $urandom_range(0, 1) == 0) begin
            for (int j = 0; j < 4; j++) begin
               send_item(make_req(MODE_TICK, ID_W'($urandom), $urandom,
                                  IVL_W'($urandom)));
               n++;
            end
         end
      end

      send_item(make_req(MODE_STOP, 8'h00, 32'd0, 31'd0));
      send_item(make_req(MODE_SCHEDULE, 8'h42, 32'd1, 31'd1));
      send_item(make_req(MODE_TICK, 8'h00, 32'd0, 31'd0));
      send_item(make_req(MODE_STOP, 8'h00, 32'd0, 31'd0));
      start <= 1'b0;

      while (expected_rsp.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);

      $display("Sent %0d transactions and checked %0d results, including full heap,",
               items_sent, rsp_seen);
      $display("time wrap, equal due times, recurring jobs and the stopped state.");
      if (mismatches == 0 && expected_rsp.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
